### src/brs_pkg.sv
`timescale 1ns / 1ps

package brs_pkg;

  localparam int CANVAS_WIDTH  = 640;
  localparam int CANVAS_HEIGHT = 420;
  localparam int TOP_ROW       = 22;
  localparam int MAX_RADIUS    = 24;
  localparam int PALETTE_SIZE  = 12;

  localparam int PAINT_ROWS   = CANVAS_HEIGHT - TOP_ROW;
  localparam int CANVAS_DEPTH = PAINT_ROWS * CANVAS_WIDTH;
  localparam int ADDR_W       = $clog2(CANVAS_DEPTH);
  localparam int ROW_W        = $clog2(PAINT_ROWS);
  localparam int COL_W        = $clog2(CANVAS_WIDTH);

  localparam int COORD_W  = 12;
  localparam int POS_W    = COORD_W + 1;
  localparam int RGB_W    = 24;
  localparam int RADIUS_W = 5;
  localparam int PAL_W    = 4;
  localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
  localparam int OFF_W    = RAD_W + 1;
  localparam int SQ_W     = 2 * RAD_W + 1;

  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  localparam logic [RGB_W-1:0] WHITE = 24'hFFFFFF;

  typedef enum logic [1:0] {
    OP_STROKE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic {
    REG_RADIUS  = 1'b0,
    REG_PALETTE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                    vld;
    logic                    paint;
    logic signed [OFF_W-1:0] ox;
    logic signed [OFF_W-1:0] oy;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
  } pix_req_t;

  typedef struct packed {
    logic              busy;
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
  } canvas_cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
  } fill_t;

  function automatic logic [RGB_W-1:0] palette_colour(input logic [PAL_W-1:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'hFFFFFF;
      4'd2:    c = 24'h808080;
      4'd3:    c = 24'hE03030;
      4'd4:    c = 24'hF08000;
      4'd5:    c = 24'hF0D000;
      4'd6:    c = 24'h30B030;
      4'd7:    c = 24'h30C0C0;
      4'd8:    c = 24'h3060E0;
      4'd9:    c = 24'h8030C0;
      4'd10:   c = 24'hE040A0;
      4'd11:   c = 24'h8B5A2B;
      default: c = 24'h000000;
    endcase
    if (int'(idx) >= PALETTE_SIZE) c = '0;
    return c;
  endfunction

endpackage

### src/brush_stroke_rasterizer.sv
`timescale 1ns / 1ps
// channel   handshake              payload
// in        in_valid / in_stall    in_op, in_start_x, in_start_y, in_end_x, in_end_y
// out       out_valid / out_stall  out_pixel_colour, out_in_canvas
// cfg       psel/penable/pwrite    paddr, pwdata, prdata, pready (always high)
//
// Read: through states S_RDA and S_RDB to the result word. Clear: S_FILL writes white over all entries.
// Stroke: n+1 centres of (2r+1)^2 pixel offsets each, n = max(|dx|,|dy|) at least 1,
// r = saturated radius; one pixel offset per cycle through the shared disc test.
// After reset a clearing pass writes white over all 254720 entries; in_stall is high
// for that time. Config writes are taken at any time.
// A stalled result word holds in the output register while the next item is accepted.

module brush_stroke_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_op,
  input  logic signed [brs_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [brs_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [brs_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [brs_pkg::COORD_W-1:0] in_end_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [brs_pkg::RGB_W-1:0]          out_pixel_colour,
  output logic                               out_in_canvas,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [brs_pkg::PADDR_W-1:0]        paddr,
  input  logic [brs_pkg::DATA_W-1:0]         pwdata,
  output logic [brs_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import brs_pkg::*;

  logic [RADIUS_W-1:0] radius_r;
  logic [PAL_W-1:0]    palette_r;
  logic                cfg_wr;
  pix_req_t            req;
  logic [2*RAD_W-1:0]  r2;
  canvas_cmd_t         cmd;
  fill_t               fill;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [RGB_W-1:0]    ram_wdata;
  logic [RGB_W-1:0]    ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RADIUS_W'(3);
      palette_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_RADIUS:  radius_r  <= pwdata[RADIUS_W-1:0];
        REG_PALETTE: palette_r <= pwdata[PAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RADIUS:  prdata = DATA_W'(radius_r);
      REG_PALETTE: prdata = DATA_W'(palette_r);
      default:     prdata = '0;
    endcase
  end

  brs_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .radius           (radius_r),
    .req              (req),
    .r2               (r2),
    .cmd              (cmd),
    .rd_data          (ram_rdata),
    .fill             (fill),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_colour (out_pixel_colour),
    .out_in_canvas    (out_in_canvas)
  );

  brs_disc u_disc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .r2    (r2),
    .cmd   (cmd)
  );

  assign ram_we    = fill.we || cmd.we;
  assign ram_addr  = fill.we ? fill.addr : cmd.addr;
  assign ram_wdata = fill.we ? WHITE : palette_colour(palette_r);

  brs_ram #(
    .WIDTH (RGB_W),
    .DEPTH (CANVAS_DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .re    (cmd.re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

### src/brs_ram.sv
`timescale 1ns / 1ps

module brs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/brs_disc.sv
`timescale 1ns / 1ps

module brs_disc (
  input  logic                       clk,
  input  logic                       rst_n,
  input  brs_pkg::pix_req_t          req,
  input  logic [2*brs_pkg::RAD_W-1:0] r2,
  output brs_pkg::canvas_cmd_t       cmd
);
  import brs_pkg::*;

  localparam logic [ADDR_W-1:0] WIDTH_A = ADDR_W'(CANVAS_WIDTH);

  logic [OFF_W-1:0]   mag_x, mag_y;
  logic [2*RAD_W-1:0] sq_x, sq_y;
  logic               in_area;
  logic [POS_W-1:0]   row_off;
  logic [ADDR_W-1:0]  row_base;

  logic               s1_vld_r;
  logic               s1_paint_r;
  logic               s1_in_r;
  logic [SQ_W-1:0]    s1_sq_r;
  logic [ADDR_W-1:0]  s1_base_r;
  logic [COL_W-1:0]   s1_col_r;
  logic               hit;

  always_comb begin
    mag_x    = req.ox[OFF_W-1] ? OFF_W'(-req.ox) : OFF_W'(req.ox);
    mag_y    = req.oy[OFF_W-1] ? OFF_W'(-req.oy) : OFF_W'(req.oy);
    sq_x     = mag_x[RAD_W-1:0] * mag_x[RAD_W-1:0];
    sq_y     = mag_y[RAD_W-1:0] * mag_y[RAD_W-1:0];
    in_area  = !req.px[POS_W-1] && (req.px < POS_W'(CANVAS_WIDTH)) &&
               (req.py >= POS_W'(TOP_ROW)) && (req.py < POS_W'(CANVAS_HEIGHT));
    row_off  = req.py - POS_W'(TOP_ROW);
    row_base = ADDR_W'(row_off[ROW_W-1:0]) * WIDTH_A;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= req.vld;
    end
    s1_paint_r <= req.paint;
    s1_in_r    <= in_area;
    s1_sq_r    <= SQ_W'(sq_x) + SQ_W'(sq_y);
    s1_base_r  <= row_base;
    s1_col_r   <= req.px[COL_W-1:0];
  end

  assign hit      = s1_sq_r <= SQ_W'(r2);
  assign cmd.busy = s1_vld_r;
  assign cmd.we   = s1_vld_r && s1_paint_r && s1_in_r && hit;
  assign cmd.re   = s1_vld_r && !s1_paint_r && s1_in_r;
  assign cmd.addr = s1_base_r + ADDR_W'(s1_col_r);

endmodule

### src/brs_seq.sv
`timescale 1ns / 1ps

module brs_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_op,
  input  logic signed [brs_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [brs_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [brs_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [brs_pkg::COORD_W-1:0] in_end_y,
  input  logic [brs_pkg::RADIUS_W-1:0]       radius,
  output brs_pkg::pix_req_t                  req,
  output logic [2*brs_pkg::RAD_W-1:0]        r2,
  input  brs_pkg::canvas_cmd_t               cmd,
  input  logic [brs_pkg::RGB_W-1:0]          rd_data,
  output brs_pkg::fill_t                     fill,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [brs_pkg::RGB_W-1:0]          out_pixel_colour,
  output logic                               out_in_canvas
);
  import brs_pkg::*;

  typedef enum logic [3:0] {
    S_FILL, S_IDLE, S_SETUP, S_CENTER, S_PIX, S_DRAIN, S_RDA, S_RDB, S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [ADDR_W-1:0]       fill_addr_r, fill_addr_nxt;
  logic                    fill_op_r, fill_op_nxt;
  logic signed [POS_W-1:0] x0_r, x0_nxt, y0_r, y0_nxt;
  logic signed [POS_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [COORD_W-1:0]      ax_r, ax_nxt, ay_r, ay_nxt;
  logic [COORD_W-1:0]      n_r, n_nxt, i_r, i_nxt;
  logic [COORD_W-1:0]      remx_r, remx_nxt, remy_r, remy_nxt;
  logic [COORD_W-1:0]      qx_r, qx_nxt, qy_r, qy_nxt;
  logic signed [POS_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [OFF_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [RAD_W-1:0]        r_r, r_nxt;
  logic [2*RAD_W-1:0]      r2_r, r2_nxt;
  logic [RGB_W-1:0]        res_colour_r, res_colour_nxt;
  logic                    res_inside_r, res_inside_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [RGB_W-1:0]        out_colour_r, out_colour_nxt;
  logic                    out_inside_r, out_inside_nxt;

  logic                    accept;
  logic [RAD_W-1:0]        r_sat;
  logic signed [OFF_W-1:0] r_pos, r_neg;
  logic [POS_W-1:0]        dx_mag, dy_mag;
  logic [COORD_W-1:0]      n_max;
  logic [COORD_W:0]        sum_x, sum_y, dif_x, dif_y;
  logic signed [POS_W-1:0] step_x, step_y;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign r_sat    = (radius > RADIUS_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius);
  assign r_pos    = OFF_W'({1'b0, r_r});
  assign r_neg    = -r_pos;
  assign dx_mag   = dx_r[POS_W-1] ? POS_W'(-dx_r) : POS_W'(dx_r);
  assign dy_mag   = dy_r[POS_W-1] ? POS_W'(-dy_r) : POS_W'(dy_r);
  assign n_max    = (dx_mag[COORD_W-1:0] > dy_mag[COORD_W-1:0]) ?
                    dx_mag[COORD_W-1:0] : dy_mag[COORD_W-1:0];
  assign sum_x    = {1'b0, remx_r} + {1'b0, ax_r};
  assign sum_y    = {1'b0, remy_r} + {1'b0, ay_r};
  assign dif_x    = sum_x - {1'b0, n_r};
  assign dif_y    = sum_y - {1'b0, n_r};
  assign step_x   = dx_r[POS_W-1] ? -$signed(POS_W'(qx_r)) : $signed(POS_W'(qx_r));
  assign step_y   = dy_r[POS_W-1] ? -$signed(POS_W'(qy_r)) : $signed(POS_W'(qy_r));

  always_comb begin
    state_nxt      = state_r;
    fill_addr_nxt  = fill_addr_r;
    fill_op_nxt    = fill_op_r;
    x0_nxt         = x0_r;
    y0_nxt         = y0_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    ax_nxt         = ax_r;
    ay_nxt         = ay_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    remx_nxt       = remx_r;
    remy_nxt       = remy_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    ox_nxt         = ox_r;
    oy_nxt         = oy_r;
    r_nxt          = r_r;
    r2_nxt         = r2_r;
    res_colour_nxt = res_colour_r;
    res_inside_nxt = res_inside_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_colour_nxt = out_colour_r;
    out_inside_nxt = out_inside_r;

    req.vld   = 1'b0;
    req.paint = 1'b1;
    req.ox    = ox_r;
    req.oy    = oy_r;
    req.px    = cx_r + POS_W'(ox_r);
    req.py    = cy_r + POS_W'(oy_r);
    fill.we   = 1'b0;
    fill.addr = fill_addr_r;

    case (state_r)
      S_FILL: begin
        fill.we = 1'b1;
        if (fill_addr_r == ADDR_W'(CANVAS_DEPTH - 1)) begin
          fill_op_nxt = 1'b0;
          state_nxt   = fill_op_r ? S_DONE : S_IDLE;
        end else begin
          fill_addr_nxt = fill_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_colour_nxt = '0;
          res_inside_nxt = 1'b0;
          case (in_op)
            OP_STROKE: begin
              x0_nxt    = POS_W'(in_start_x);
              y0_nxt    = POS_W'(in_start_y);
              dx_nxt    = POS_W'(in_end_x) - POS_W'(in_start_x);
              dy_nxt    = POS_W'(in_end_y) - POS_W'(in_start_y);
              r_nxt     = r_sat;
              state_nxt = S_SETUP;
            end
            OP_READ: begin
              req.vld   = 1'b1;
              req.paint = 1'b0;
              req.ox    = '0;
              req.oy    = '0;
              req.px    = POS_W'(in_start_x);
              req.py    = POS_W'(in_start_y);
              state_nxt = S_RDA;
            end
            OP_CLEAR: begin
              fill_addr_nxt = '0;
              fill_op_nxt   = 1'b1;
              state_nxt     = S_FILL;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SETUP: begin
        ax_nxt    = dx_mag[COORD_W-1:0];
        ay_nxt    = dy_mag[COORD_W-1:0];
        n_nxt     = (n_max == '0) ? COORD_W'(1) : n_max;
        i_nxt     = '0;
        remx_nxt  = '0;
        remy_nxt  = '0;
        qx_nxt    = '0;
        qy_nxt    = '0;
        r2_nxt    = r_r * r_r;
        state_nxt = S_CENTER;
      end
      S_CENTER: begin
        cx_nxt    = x0_r + step_x;
        cy_nxt    = y0_r + step_y;
        ox_nxt    = r_neg;
        oy_nxt    = r_neg;
        state_nxt = S_PIX;
      end
      S_PIX: begin
        req.vld = 1'b1;
        if (ox_r == r_pos) begin
          ox_nxt = r_neg;
          if (oy_r == r_pos) begin
            if (i_r == n_r) begin
              state_nxt = S_DRAIN;
            end else begin
              i_nxt = i_r + 1'b1;
              if (sum_x >= {1'b0, n_r}) begin
                remx_nxt = dif_x[COORD_W-1:0];
                qx_nxt   = qx_r + 1'b1;
              end else begin
                remx_nxt = sum_x[COORD_W-1:0];
              end
              if (sum_y >= {1'b0, n_r}) begin
                remy_nxt = dif_y[COORD_W-1:0];
                qy_nxt   = qy_r + 1'b1;
              end else begin
                remy_nxt = sum_y[COORD_W-1:0];
              end
              state_nxt = S_CENTER;
            end
          end else begin
            oy_nxt = oy_r + 1'b1;
          end
        end else begin
          ox_nxt = ox_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!cmd.busy) state_nxt = S_DONE;
      end
      S_RDA: begin
        res_inside_nxt = cmd.re;
        state_nxt      = S_RDB;
      end
      S_RDB: begin
        res_colour_nxt = res_inside_r ? rd_data : '0;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_colour_nxt = res_colour_r;
          out_inside_nxt = res_inside_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      fill_addr_r <= '0;
      fill_op_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_op_r   <= fill_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x0_r         <= x0_nxt;
    y0_r         <= y0_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    ax_r         <= ax_nxt;
    ay_r         <= ay_nxt;
    n_r          <= n_nxt;
    i_r          <= i_nxt;
    remx_r       <= remx_nxt;
    remy_r       <= remy_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    ox_r         <= ox_nxt;
    oy_r         <= oy_nxt;
    r_r          <= r_nxt;
    r2_r         <= r2_nxt;
    res_colour_r <= res_colour_nxt;
    res_inside_r <= res_inside_nxt;
    out_colour_r <= out_colour_nxt;
    out_inside_r <= out_inside_nxt;
  end

  assign r2               = r2_r;
  assign out_valid        = out_valid_r;
  assign out_pixel_colour = out_colour_r;
  assign out_in_canvas    = out_inside_r;

endmodule

### src/brs_checker.sv
`timescale 1ns / 1ps

module brs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [brs_pkg::RGB_W-1:0]    out_pixel_colour,
  input logic                         out_in_canvas
);

  // word held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_colour) &&
    $stable(out_in_canvas))
    else $error("result word changed under stall");

  a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_canvas |-> out_pixel_colour == '0)
    else $error("nonzero colour outside canvas");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted word while previous one in progress");

  a_fill_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during clearing pass");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind brush_stroke_rasterizer brs_checker u_brs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pixel_colour (out_pixel_colour),
  .out_in_canvas    (out_in_canvas)
);

### test/brush_stroke_checker.sv
`timescale 1ns / 1ps

module brush_stroke_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [1:0]                         in_op,
  input  logic signed [brs_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [brs_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [brs_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [brs_pkg::COORD_W-1:0] in_end_y,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [brs_pkg::RGB_W-1:0]          out_pixel_colour,
  input  logic                               out_in_canvas,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [brs_pkg::PADDR_W-1:0]        paddr,
  input  logic [brs_pkg::DATA_W-1:0]         pwdata,
  output int unsigned                        errors,
  output int unsigned                        pending
);
  import brs_pkg::*;

  typedef struct packed {
    logic [RGB_W-1:0] colour;
    logic             on_canvas;
  } pixel_word_t;

  // entry 0 in the low bits
  localparam logic [RGB_W*PALETTE_SIZE-1:0] SWATCHES = {
    24'h8B5A2B, 24'hE040A0, 24'h8030C0, 24'h3060E0, 24'h30C0C0, 24'h30B030,
    24'hF0D000, 24'hF08000, 24'hE03030, 24'h808080, 24'hFFFFFF, 24'h000000
  };

  logic [RGB_W-1:0]    paint_mem [CANVAS_DEPTH];
  logic [RADIUS_W-1:0] brush_size;
  logic [PAL_W-1:0]    colour_sel;
  pixel_word_t         due_q [$];
  int unsigned         mismatches;
  bit                  wiped;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 50) begin
      $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic void wipe();
    for (int k = 0; k < CANVAS_DEPTH; k++) paint_mem[k] = WHITE;
  endfunction

  function automatic void paint_segment(int x0, int y0, int x1, int y1);
    int dx, dy, n, r, cx, cy, px, py, i, ox, oy;
    logic [RGB_W-1:0] ink;
    dx = x1 - x0;
    dy = y1 - y0;
    n = (dx < 0) ? -dx : dx;
    if (((dy < 0) ? -dy : dy) > n) n = (dy < 0) ? -dy : dy;
    if (n < 1) n = 1;
    r = (brush_size > MAX_RADIUS) ? MAX_RADIUS : int'(brush_size);
    ink = (colour_sel < PALETTE_SIZE) ? SWATCHES[colour_sel*RGB_W +: RGB_W] : '0;
    for (i = 0; i <= n; i++) begin
      cx = x0 + (dx * i) / n;
      cy = y0 + (dy * i) / n;
      if (cx + r < 0 || cx - r >= CANVAS_WIDTH || cy + r < TOP_ROW ||
          cy - r >= CANVAS_HEIGHT) continue;
      for (oy = -r; oy <= r; oy++) begin
        py = cy + oy;
        if (py < TOP_ROW || py >= CANVAS_HEIGHT) continue;
        for (ox = -r; ox <= r; ox++) begin
          px = cx + ox;
          if (px < 0 || px >= CANVAS_WIDTH) continue;
          if (ox * ox + oy * oy <= r * r) paint_mem[(py - TOP_ROW) * CANVAS_WIDTH + px] = ink;
        end
      end
    end
  endfunction

  function automatic pixel_word_t look_up(int x, int y);
    pixel_word_t w;
    w = '0;
    if (x >= 0 && x < CANVAS_WIDTH && y >= TOP_ROW && y < CANVAS_HEIGHT) begin
      w.colour    = paint_mem[(y - TOP_ROW) * CANVAS_WIDTH + x];
      w.on_canvas = 1'b1;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    pixel_word_t got, want;
    if (!rst_n) begin
      if (!wiped) wipe();
      wiped = 1'b1;
      brush_size = 5'd3;
      colour_sel = '0;
      due_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.colour    = out_pixel_colour;
        got.on_canvas = out_in_canvas;
        if (due_q.size() == 0) begin
          report("unexpected word", {7'd0, got}, '0);
        end else begin
          want = due_q.pop_front();
          if (got.colour !== want.colour) begin
            report("pixel_colour", 32'(got.colour), 32'(want.colour));
          end
          if (got.on_canvas !== want.on_canvas) begin
            report("in_canvas", 32'(got.on_canvas), 32'(want.on_canvas));
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_RADIUS:  brush_size = pwdata[RADIUS_W-1:0];
          REG_PALETTE: colour_sel = pwdata[PAL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = '0;
        case (op_t'(in_op))
          OP_STROKE: paint_segment(in_start_x, in_start_y, in_end_x, in_end_y);
          OP_READ:   want = look_up(in_start_x, in_start_y);
          OP_CLEAR:  wipe();
          default: ;
        endcase
        due_q.push_back(want);
      end
    end
    errors  <= mismatches;
    pending <= due_q.size();
  end

endmodule

### test/brush_stroke_rasterizer_test.sv
`timescale 1ns / 1ps

module brush_stroke_rasterizer_test;
  import brs_pkg::*;

  localparam int WATCH_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 35;
  localparam int SETTLE      = 12;
  localparam int PHASE_WORDS = 19;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                in_op;
  logic signed [COORD_W-1:0] in_start_x;
  logic signed [COORD_W-1:0] in_start_y;
  logic signed [COORD_W-1:0] in_end_x;
  logic signed [COORD_W-1:0] in_end_y;
  logic                      out_valid;
  logic                      out_stall;
  logic [RGB_W-1:0]          out_pixel_colour;
  logic                      out_in_canvas;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  int unsigned chk_errors;
  int unsigned chk_pending;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned n_sent = 0;
  int unsigned n_stroke = 0, n_read = 0, n_clear = 0, n_noop = 0, n_cfg = 0;
  int          cur_radius;
  int          last_x0, last_y0, last_x1, last_y1;

  always #5 clk = ~clk;

  brush_stroke_rasterizer u_dut (.*);

  brush_stroke_checker u_checker (
    .errors (chk_errors),
    .pending(chk_pending),
    .*
  );

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) words_in <= words_in + 1;
    if (rst_n && out_valid && !out_stall) words_out <= words_out + 1;
  end

  function automatic int clip12(int v);
    return (v < -2048) ? -2048 : ((v > 2047) ? 2047 : v);
  endfunction

  function automatic int any12();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int pick_gap(int unsigned count);
    return (count % 32 < 8) ? 0 : int'($urandom_range(0, 18));
  endfunction

  task automatic send_word(op_t op, int sx, int sy, int ex, int ey);
    int gap;
    gap = pick_gap(n_sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_start_x <= sx[COORD_W-1:0];
    in_start_y <= sy[COORD_W-1:0];
    in_end_x   <= ex[COORD_W-1:0];
    in_end_y   <= ey[COORD_W-1:0];
    do @(posedge clk); while (!(in_valid && !in_stall));
    n_sent++;
    case (op)
      OP_STROKE: n_stroke++;
      OP_READ:   n_read++;
      OP_CLEAR:  n_clear++;
      default:   n_noop++;
    endcase
  endtask

  task automatic stroke(int sx, int sy, int ex, int ey);
    last_x0 = sx;
    last_y0 = sy;
    last_x1 = ex;
    last_y1 = ey;
    send_word(OP_STROKE, sx, sy, ex, ey);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_out != words_in) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx == REG_RADIUS) cur_radius = int'(value[RADIUS_W-1:0]);
    n_cfg++;
  endtask

  task automatic random_word();
    int pick, sub, sx, sy, ex, ey, rr, reach;
    rr = (cur_radius > MAX_RADIUS) ? MAX_RADIUS : cur_radius;
    reach = (rr >= 12) ? 2 : ((rr >= 4) ? 10 : 40);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 4) != 0) begin
        sx = int'($urandom_range(0, CANVAS_WIDTH + 39)) - 20;
        sy = int'($urandom_range(TOP_ROW - 20, CANVAS_HEIGHT + 19));
      end else begin
        sx = any12();
        sy = any12();
      end
      ex = clip12(sx + int'($urandom_range(0, 2 * reach)) - reach);
      ey = clip12(sy + int'($urandom_range(0, 2 * reach)) - reach);
      stroke(sx, sy, ex, ey);
    end else if (pick < 90) begin
      sub = $urandom_range(0, 9);
      if (sub < 5) begin
        sx = ($urandom_range(0, 1) != 0) ? last_x0 : last_x1;
        sy = ($urandom_range(0, 1) != 0) ? last_y0 : last_y1;
        sx = clip12(sx + int'($urandom_range(0, 2 * rr + 4)) - rr - 2);
        sy = clip12(sy + int'($urandom_range(0, 2 * rr + 4)) - rr - 2);
      end else if (sub < 8) begin
        sx = int'($urandom_range(0, CANVAS_WIDTH + 3)) - 2;
        sy = int'($urandom_range(TOP_ROW - 2, CANVAS_HEIGHT + 1));
      end else begin
        sx = any12();
        sy = any12();
      end
      send_word(OP_READ, sx, sy, any12(), any12());
    end else begin
      send_word(OP_NONE, any12(), any12(), any12(), any12());
    end
  endtask

  // result side: random stall after taken words outside stall-free runs, one long hold to back up the block
  initial begin : sink
    int gap;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (!held && words_out >= HOLD_AT) begin
          held = 1'b1;
          gap = HOLD_CYCLES;
        end else if (words_out % 40 < 10) begin
          gap = 0;
        end else begin
          gap = $urandom_range(0, 18);
        end
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCH_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int phase, k;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_op      <= OP_NONE;
    in_start_x <= '0;
    in_start_y <= '0;
    in_end_x   <= '0;
    in_end_y   <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    cur_radius = 3;
    last_x0 = 100;
    last_y0 = 100;
    last_x1 = 100;
    last_y1 = 100;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // fresh canvas, edges of the paintable area, out-of-range reads
    send_word(OP_READ, 100, 100, 0, 0);
    send_word(OP_READ, 0, TOP_ROW, 0, 0);
    send_word(OP_READ, CANVAS_WIDTH - 1, CANVAS_HEIGHT - 1, 0, 0);
    send_word(OP_READ, -1, 50, 0, 0);
    send_word(OP_READ, CANVAS_WIDTH, 50, 0, 0);
    send_word(OP_READ, 50, TOP_ROW - 1, 0, 0);
    send_word(OP_READ, 50, CANVAS_HEIGHT, 0, 0);
    send_word(OP_READ, -2048, -2048, 2047, 2047);
    send_word(OP_NONE, 2047, 2047, -2048, -2048);
    // single disc from equal endpoints, default radius and colour
    stroke(100, 100, 100, 100);
    send_word(OP_READ, 103, 100, 0, 0);
    send_word(OP_READ, 103, 101, 0, 0);
    send_word(OP_READ, 102, 102, 0, 0);
    settle();

    // zero radius, full-range diagonals
    set_reg(REG_RADIUS, 32'd0);
    set_reg(REG_PALETTE, 32'd5);
    stroke(-2048, -2048, 2047, 2047);
    send_word(OP_READ, 30, 30, 0, 0);
    send_word(OP_READ, 31, 30, 0, 0);
    stroke(2047, -2048, -2048, 2047);
    settle();

    // radius saturates, palette index past the table paints black
    set_reg(REG_RADIUS, 32'd31);
    set_reg(REG_PALETTE, 32'd15);
    stroke(320, 200, 322, 200);
    send_word(OP_READ, 346, 200, 0, 0);
    send_word(OP_READ, 347, 200, 0, 0);
    send_word(OP_READ, 320, 225, 0, 0);
    stroke(0, TOP_ROW, 0, TOP_ROW);
    send_word(OP_READ, 0, TOP_ROW, 0, 0);
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_READ, 320, 200, 0, 0);
    send_word(OP_READ, 30, 30, 0, 0);
    settle();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_reg(REG_RADIUS, $urandom_range(1, 6));
        1: set_reg(REG_RADIUS, 32'd0);
        2: set_reg(REG_RADIUS, $urandom_range(MAX_RADIUS, 31));
        default: set_reg(REG_RADIUS, $urandom_range(0, 31));
      endcase
      set_reg(REG_PALETTE, (phase == 1) ? $urandom_range(1, 11) : $urandom_range(0, 15));
      for (k = 0; k < PHASE_WORDS; k++) random_word();
      settle();
    end

    $display("covered %0d words: %0d strokes, %0d reads, %0d clears, %0d unused ops",
             n_sent, n_stroke, n_read, n_clear, n_noop);
    $display("with %0d register writes over radius 0..31 and palette 0..15, one long result hold",
             n_cfg);
    if (chk_errors == 0 && chk_pending == 0 && words_out == words_in) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
